// ===== src/ramn_pkg.sv =====
// Shared types and constants for the Ricart-Agrawala mutual exclusion node.
`default_nettype none

package ramn_pkg;

    localparam int MaxNodesDefault = 16;
    localparam int PeerSlots       = 16;
    localparam int ClockW          = 16;
    localparam int CountW          = 5;
    localparam int PeerW           = 4;
    localparam int OpW             = 2;
    localparam int KindW           = 2;
    localparam int CfgIndexW       = 2;
    localparam int CfgDataW        = 5;
    localparam int TdataW          = 24;

    localparam logic [ClockW-1:0] CLOCK_MAX = 16'hFFFF;

    localparam logic [OpW-1:0] OP_LOCAL_REQ = 2'd0;
    localparam logic [OpW-1:0] OP_LOCAL_REL = 2'd1;
    localparam logic [OpW-1:0] OP_RECV_REQ  = 2'd2;
    localparam logic [OpW-1:0] OP_RECV_REP  = 2'd3;

    localparam logic [KindW-1:0] KIND_REQUEST = 2'd0;
    localparam logic [KindW-1:0] KIND_REPLY   = 2'd1;
    localparam logic [KindW-1:0] KIND_ENTER   = 2'd2;

    localparam logic [CfgIndexW-1:0] CFG_NODE_ID    = 2'd0;
    localparam logic [CfgIndexW-1:0] CFG_NODE_COUNT = 2'd1;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_SCAN = 2'b10
    } state_t;

    typedef struct packed {
        logic load;
        logic step;
    } ctrl_cmd_t;

    typedef struct packed {
        logic out_free;
        logic start_scan;
        logic scan_last;
    } dp_sts_t;

endpackage

`default_nettype wire

// ===== src/ramn_ctrl.sv =====
// Controller state machine: item acceptance and message scan sequencing.
`default_nettype none

module ramn_ctrl (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  s_tvalid,
    output logic                 s_tready,
    input  ramn_pkg::dp_sts_t    sts,
    output ramn_pkg::ctrl_cmd_t  cmd
);
    import ramn_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        s_tready = (state_reg == ST_IDLE) && sts.out_free;
        cmd.load = s_tvalid && s_tready;
        cmd.step = (state_reg == ST_SCAN) && sts.out_free;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd.load && sts.start_scan)
                    state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (cmd.step && sts.scan_last)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    a_no_load_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> !cmd.load)
        else $error("item accepted during scan");

    a_scan_ends_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.step && sts.scan_last) |=> (state_reg == ST_IDLE))
        else $error("scan did not return to idle");

    a_start_enters_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load && sts.start_scan) |=> (state_reg == ST_SCAN))
        else $error("scan not started");

endmodule

`default_nettype wire

// ===== src/ramn_dp.sv =====
// Datapath: node state, Lamport clock, deferral bitmap, scan mask and output register.
`default_nettype none

module ramn_dp #(
    parameter int MAX_NODES = ramn_pkg::MaxNodesDefault
) (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire                                 cfg_valid,
    output logic                                cfg_ready,
    input  wire  [ramn_pkg::CfgIndexW-1:0]      cfg_index,
    input  wire  [ramn_pkg::CfgDataW-1:0]       cfg_data,
    input  wire  [ramn_pkg::OpW-1:0]            op,
    input  wire  [ramn_pkg::PeerW-1:0]          peer,
    input  wire  [ramn_pkg::ClockW-1:0]         stamp,
    input  wire                                 m_tready,
    output logic                                m_tvalid,
    output logic [ramn_pkg::KindW-1:0]          msg_kind,
    output logic [ramn_pkg::PeerW-1:0]          dest,
    output logic [ramn_pkg::ClockW-1:0]         out_stamp,
    output logic                                last,
    input  ramn_pkg::ctrl_cmd_t                 cmd,
    output ramn_pkg::dp_sts_t                   sts
);
    import ramn_pkg::*;

    localparam int Slots = (MAX_NODES < PeerSlots) ? MAX_NODES : PeerSlots;
    localparam int IdxW  = $clog2(Slots);
    localparam logic [CountW-1:0] SLOTS_C = CountW'(Slots);

    logic [PeerW-1:0]     node_id_reg;
    logic [CountW-1:0]    node_count_reg;
    logic [ClockW-1:0]    clock_reg, clock_next;
    logic                 requesting_reg, requesting_next;
    logic [ClockW-1:0]    req_stamp_reg, req_stamp_next;
    logic [CountW-1:0]    pending_reg, pending_next;
    logic [Slots-1:0]     deferred_reg, deferred_next;
    logic [PeerSlots-1:0] mask_reg, mask_next;
    logic [KindW-1:0]     scan_kind_reg, scan_kind_next;
    logic                 ovalid_reg, ovalid_next;
    logic [KindW-1:0]     okind_reg, okind_next;
    logic [PeerW-1:0]     odest_reg, odest_next;
    logic [ClockW-1:0]    ostamp_reg, ostamp_next;
    logic                 olast_reg, olast_next;

    logic [CountW-1:0]    part_cnt;
    logic [PeerSlots-1:0] pmask;
    logic [PeerSlots-1:0] req_mask;
    logic [PeerSlots-1:0] rel_mask;
    logic [PeerSlots-1:0] mask_clr;
    logic [CountW-1:0]    peer_cnt;
    logic                 self_in;
    logic                 peer_ok;
    logic                 mine_first;
    logic [ClockW-1:0]    clk_inc;
    logic [ClockW-1:0]    clk_max;
    logic [ClockW-1:0]    clk_recv;
    logic [PeerW-1:0]     scan_idx;
    logic                 emit;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        part_cnt = (node_count_reg < SLOTS_C) ? node_count_reg : SLOTS_C;
        for (int i = 0; i < PeerSlots; i++)
            pmask[i] = (CountW'(i) < part_cnt);
        self_in  = ({1'b0, node_id_reg} < part_cnt);
        peer_cnt = part_cnt - {{(CountW-1){1'b0}}, self_in};
        req_mask = pmask & ~(PeerSlots'(1) << node_id_reg);
        rel_mask = PeerSlots'(deferred_reg) & pmask;
        peer_ok  = (peer != node_id_reg) && ({1'b0, peer} < part_cnt);
        clk_inc  = (clock_reg == CLOCK_MAX) ? CLOCK_MAX : clock_reg + 1'b1;
        clk_max  = (clock_reg > stamp) ? clock_reg : stamp;
        clk_recv = (clk_max == CLOCK_MAX) ? CLOCK_MAX : clk_max + 1'b1;
        mine_first = requesting_reg &&
            ((req_stamp_reg < stamp) || ((req_stamp_reg == stamp) && (node_id_reg < peer)));
        scan_idx = '0;
        for (int i = PeerSlots - 1; i >= 0; i--)
            if (mask_reg[i])
                scan_idx = PeerW'(i);
        mask_clr = mask_reg & ~(PeerSlots'(1) << scan_idx);
    end

    always_comb
    begin
        clock_next      = clock_reg;
        requesting_next = requesting_reg;
        req_stamp_next  = req_stamp_reg;
        pending_next    = pending_reg;
        deferred_next   = deferred_reg;
        mask_next       = mask_reg;
        scan_kind_next  = scan_kind_reg;
        okind_next      = okind_reg;
        odest_next      = odest_reg;
        ostamp_next     = ostamp_reg;
        olast_next      = olast_reg;
        emit            = 1'b0;
        sts.start_scan  = 1'b0;
        sts.scan_last   = (mask_clr == '0);

        if (cmd.load)
        begin
            case (op)
                OP_LOCAL_REQ:
                begin
                    if (!requesting_reg)
                    begin
                        clock_next      = clk_inc;
                        req_stamp_next  = clk_inc;
                        requesting_next = 1'b1;
                        pending_next    = peer_cnt;
                        mask_next       = req_mask;
                        scan_kind_next  = KIND_REQUEST;
                        if (peer_cnt == '0)
                        begin
                            emit        = 1'b1;
                            okind_next  = KIND_ENTER;
                            odest_next  = node_id_reg;
                            ostamp_next = clk_inc;
                            olast_next  = 1'b1;
                        end
                        else
                            sts.start_scan = 1'b1;
                    end
                end
                OP_LOCAL_REL:
                begin
                    requesting_next = 1'b0;
                    pending_next    = '0;
                    deferred_next   = '0;
                    mask_next       = rel_mask;
                    scan_kind_next  = KIND_REPLY;
                    sts.start_scan  = (rel_mask != '0);
                end
                OP_RECV_REQ:
                begin
                    if (peer_ok)
                    begin
                        clock_next = clk_recv;
                        if (mine_first)
                            deferred_next[peer[IdxW-1:0]] = 1'b1;
                        else
                        begin
                            emit        = 1'b1;
                            okind_next  = KIND_REPLY;
                            odest_next  = peer;
                            ostamp_next = clk_recv;
                            olast_next  = 1'b1;
                        end
                    end
                end
                OP_RECV_REP:
                begin
                    if (peer_ok)
                    begin
                        clock_next = clk_recv;
                        if (requesting_reg && (pending_reg != '0))
                        begin
                            pending_next = pending_reg - 1'b1;
                            if (pending_reg == CountW'(1))
                            begin
                                emit        = 1'b1;
                                okind_next  = KIND_ENTER;
                                odest_next  = node_id_reg;
                                ostamp_next = req_stamp_reg;
                                olast_next  = 1'b1;
                            end
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
        else if (cmd.step)
        begin
            emit        = 1'b1;
            mask_next   = mask_clr;
            okind_next  = scan_kind_reg;
            odest_next  = scan_idx;
            ostamp_next = (scan_kind_reg == KIND_REQUEST) ? req_stamp_reg : clock_reg;
            olast_next  = (mask_clr == '0);
        end

        if (emit)
            ovalid_next = 1'b1;
        else if (m_tready)
            ovalid_next = 1'b0;
        else
            ovalid_next = ovalid_reg;

        sts.out_free = !ovalid_reg || m_tready;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_id_reg    <= '0;
            node_count_reg <= CountW'(1);
            clock_reg      <= '0;
            requesting_reg <= 1'b0;
            req_stamp_reg  <= '0;
            pending_reg    <= '0;
            deferred_reg   <= '0;
            mask_reg       <= '0;
            scan_kind_reg  <= KIND_REQUEST;
            ovalid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_index == CFG_NODE_ID)
                node_id_reg <= cfg_data[PeerW-1:0];
            if (cfg_valid && cfg_index == CFG_NODE_COUNT)
                node_count_reg <= cfg_data;
            clock_reg      <= clock_next;
            requesting_reg <= requesting_next;
            req_stamp_reg  <= req_stamp_next;
            pending_reg    <= pending_next;
            deferred_reg   <= deferred_next;
            mask_reg       <= mask_next;
            scan_kind_reg  <= scan_kind_next;
            ovalid_reg     <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        okind_reg  <= okind_next;
        odest_reg  <= odest_next;
        ostamp_reg <= ostamp_next;
        olast_reg  <= olast_next;
    end

    assign m_tvalid  = ovalid_reg;
    assign msg_kind  = okind_reg;
    assign dest      = odest_reg;
    assign out_stamp = ostamp_reg;
    assign last      = olast_reg;

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> sts.out_free)
        else $error("output register overwritten");

    a_pending_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !requesting_reg |-> (pending_reg == '0))
        else $error("replies pending while not requesting");

    a_step_has_work: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |-> (mask_reg != '0))
        else $error("scan step with empty mask");

endmodule

`default_nettype wire

// ===== src/ricart_agrawala_mutex_node_top.sv =====
// Top level of one Ricart-Agrawala mutual exclusion node.
//
//  channel  dir  handshake            payload
//  s_*      in   s_tvalid/s_tready    s_tdata: op, peer, stamp
//  m_*      out  m_tvalid/m_tready    m_tdata: msg_kind, dest, out_stamp; m_tlast: last
//  cfg_*    in   cfg_valid/cfg_ready  cfg_index, cfg_data (node_id, node_count)
//
// Received messages and stray items are handled on acceptance; a request or release then
// sends one message per cycle while the output is free, one per peer or deferred peer,
// paced by the single output register. No item is accepted while that scan runs.
// Output stalls hold the scan; reset clears all node state and the deferral map.
`default_nettype none

module ricart_agrawala_mutex_node_top #(
    parameter int MAX_NODES = ramn_pkg::MaxNodesDefault
) (
    input  wire                             clk,
    input  wire                             rst_n,
    input  wire                             s_tvalid,
    output logic                            s_tready,
    input  wire  [ramn_pkg::TdataW-1:0]     s_tdata,   // op[1:0], peer[5:2], stamp[21:6], zero
    output logic                            m_tvalid,
    input  wire                             m_tready,
    output logic [ramn_pkg::TdataW-1:0]     m_tdata,   // msg_kind[1:0], dest[5:2], out_stamp[21:6]
    output logic                            m_tlast,
    input  wire                             cfg_valid,
    output logic                            cfg_ready,
    input  wire  [ramn_pkg::CfgIndexW-1:0]  cfg_index,
    input  wire  [ramn_pkg::CfgDataW-1:0]   cfg_data
);
    import ramn_pkg::*;

    ctrl_cmd_t          cmd;
    dp_sts_t            sts;
    logic [KindW-1:0]   msg_kind;
    logic [PeerW-1:0]   dest;
    logic [ClockW-1:0]  out_stamp;

    ramn_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    ramn_dp #(
        .MAX_NODES (MAX_NODES)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .op        (s_tdata[1:0]),
        .peer      (s_tdata[5:2]),
        .stamp     (s_tdata[21:6]),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .msg_kind  (msg_kind),
        .dest      (dest),
        .out_stamp (out_stamp),
        .last      (m_tlast),
        .cmd       (cmd),
        .sts       (sts)
    );

    assign m_tdata = {2'b00, out_stamp, dest, msg_kind};

endmodule

`default_nettype wire

// ===== tb/ricart_agrawala_mutex_node_checker.sv =====
// Checker for the mutual exclusion node: predicts node messages and compares them.
`timescale 1ns / 1ps

module ricart_agrawala_mutex_node_checker #(
    parameter int MAX_NODES = 16
) (
    input  wire                             clk,
    input  wire                             rst_n,
    input  wire                             s_tvalid,
    input  wire                             s_tready,
    input  wire  [ramn_pkg::TdataW-1:0]     s_tdata,   // op[1:0], peer[5:2], stamp[21:6], zero
    input  wire                             m_tvalid,
    input  wire                             m_tready,
    input  wire  [ramn_pkg::TdataW-1:0]     m_tdata,   // msg_kind[1:0], dest[5:2], out_stamp[21:6]
    input  wire                             m_tlast,
    input  wire                             cfg_valid,
    input  wire                             cfg_ready,
    input  wire  [ramn_pkg::CfgIndexW-1:0]  cfg_index,
    input  wire  [ramn_pkg::CfgDataW-1:0]   cfg_data,
    output int                              fail_count,
    output int                              pending,
    output int                              result_count,
    output logic [ramn_pkg::ClockW-1:0]     lamport_now,
    output logic [ramn_pkg::ClockW-1:0]     req_stamp_now
);

    import ramn_pkg::*;

    typedef struct packed {
        logic [KindW-1:0]  kind;
        logic [PeerW-1:0]  dest;
        logic [ClockW-1:0] stamp;
        logic              last;
    } node_msg_t;

    logic [ClockW-1:0]    lamport_q;
    logic [ClockW-1:0]    req_stamp_q;
    logic                 requesting_q;
    logic [CountW-1:0]    replies_left_q;
    logic [PeerSlots-1:0] deferred_q;
    logic [PeerW-1:0]     node_id_q;
    logic [CountW-1:0]    node_count_q;

    node_msg_t node_msgs_due[$];
    node_msg_t want_msg;
    int        errors;
    int        results;

    function automatic int participant_count();
        int n;
        n = int'(node_count_q);
        if (n > MAX_NODES)
            n = MAX_NODES;
        if (n > PeerSlots)
            n = PeerSlots;
        return n;
    endfunction

    function automatic logic [ClockW-1:0] clock_after(input logic [ClockW-1:0] seen);
        logic [ClockW-1:0] larger;
        larger = (lamport_q > seen) ? lamport_q : seen;
        return (larger == CLOCK_MAX) ? larger : larger + 1'b1;
    endfunction

    function automatic node_msg_t make_msg(input logic [KindW-1:0] kind,
                                           input logic [PeerW-1:0] dest,
                                           input logic [ClockW-1:0] stamp);
        node_msg_t m;
        m.kind  = kind;
        m.dest  = dest;
        m.stamp = stamp;
        m.last  = 1'b0;
        return m;
    endfunction

    task automatic predict_node_messages(input logic [OpW-1:0] op,
                                         input logic [PeerW-1:0] peer,
                                         input logic [ClockW-1:0] stamp);
        int        n;
        logic      mine_first;
        node_msg_t batch[$];
        n = participant_count();
        case (op)
            OP_LOCAL_REQ:
            begin
                if (!requesting_q)
                begin
                    lamport_q    = clock_after(lamport_q);
                    req_stamp_q  = lamport_q;
                    requesting_q = 1'b1;
                    for (int i = 0; i < n; i++)
                        if (i != node_id_q)
                            batch.push_back(make_msg(KIND_REQUEST, PeerW'(i), req_stamp_q));
                    replies_left_q = CountW'(batch.size());
                    if (batch.size() == 0)
                        batch.push_back(make_msg(KIND_ENTER, node_id_q, req_stamp_q));
                end
            end
            OP_LOCAL_REL:
            begin
                requesting_q   = 1'b0;
                replies_left_q = '0;
                for (int i = 0; i < n; i++)
                    if (deferred_q[i])
                        batch.push_back(make_msg(KIND_REPLY, PeerW'(i), lamport_q));
                deferred_q = '0;
            end
            default:
            begin
                if (peer != node_id_q && peer < n)
                begin
                    lamport_q = clock_after(stamp);
                    if (op == OP_RECV_REQ)
                    begin
                        mine_first = requesting_q && (req_stamp_q < stamp ||
                                     (req_stamp_q == stamp && node_id_q < peer));
                        if (mine_first)
                            deferred_q[peer] = 1'b1;
                        else
                            batch.push_back(make_msg(KIND_REPLY, peer, lamport_q));
                    end
                    else if (requesting_q && replies_left_q != 0)
                    begin
                        replies_left_q = replies_left_q - 1'b1;
                        if (replies_left_q == 0)
                            batch.push_back(make_msg(KIND_ENTER, node_id_q, req_stamp_q));
                    end
                end
            end
        endcase
        if (batch.size() > 0)
            batch[batch.size()-1].last = 1'b1;
        foreach (batch[j])
            node_msgs_due.push_back(batch[j]);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lamport_q      = '0;
            req_stamp_q    = '0;
            requesting_q   = 1'b0;
            replies_left_q = '0;
            deferred_q     = '0;
            node_id_q      = '0;
            node_count_q   = CountW'(1);
            node_msgs_due.delete();
            errors         = 0;
            results        = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                results++;
                if (node_msgs_due.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected item: kind %0d dest %0d stamp %0d last %0d",
                             $time, m_tdata[1:0], m_tdata[5:2], m_tdata[21:6], m_tlast);
                end
                else
                begin
                    want_msg = node_msgs_due.pop_front();
                    if (want_msg.kind != m_tdata[1:0] || want_msg.dest != m_tdata[5:2] ||
                        want_msg.stamp != m_tdata[21:6] || want_msg.last != m_tlast)
                    begin
                        errors++;
                        $display("%0t: mismatch: expected kind %0d dest %0d stamp %0d last %0d",
                                 $time, want_msg.kind, want_msg.dest, want_msg.stamp,
                                 want_msg.last);
                        $display("%0t:           actual kind %0d dest %0d stamp %0d last %0d",
                                 $time, m_tdata[1:0], m_tdata[5:2], m_tdata[21:6], m_tlast);
                    end
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_NODE_ID)
                    node_id_q = cfg_data[PeerW-1:0];
                else if (cfg_index == CFG_NODE_COUNT)
                    node_count_q = cfg_data;
            end
            if (s_tvalid && s_tready)
                predict_node_messages(s_tdata[1:0], s_tdata[5:2], s_tdata[21:6]);
        end
        fail_count    <= errors;
        pending       <= node_msgs_due.size();
        result_count  <= results;
        lamport_now   <= lamport_q;
        req_stamp_now <= req_stamp_q;
    end

endmodule

// ===== tb/ricart_agrawala_mutex_node_top_tb.sv =====
// Testbench top: clock, reset, stimulus and verdict for the mutual exclusion node.
`timescale 1ns / 1ps

module ricart_agrawala_mutex_node_top_tb;

    import ramn_pkg::*;

    localparam int CYCLE_LIMIT  = 600000;
    localparam int RANDOM_ITEMS = 240;
    localparam int DRAIN_CYCLES = 24;
    localparam int HOLD_CYCLES  = 400;
    localparam int FINAL_WAIT   = 5000;

    // index with no register behind it; writes must be ignored
    localparam logic [CfgIndexW-1:0] CFG_SPARE = 2'd3;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [TdataW-1:0]    s_tdata   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [TdataW-1:0]    m_tdata;
    logic                 m_tlast;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CfgIndexW-1:0] cfg_index = '0;
    logic [CfgDataW-1:0]  cfg_data  = '0;

    int                   fail_count;
    int                   pending;
    int                   result_count;
    logic [ClockW-1:0]    lamport_now;
    logic [ClockW-1:0]    req_stamp_now;

    int                   sent_items    = 0;
    int                   burst_left    = 0;
    int                   cycle_count   = 0;
    int                   hold_asks     = 0;
    int                   hold_seen     = 0;
    int                   hold_left     = 0;
    int                   rx_mode       = 0;
    int                   rx_left       = 0;
    int                   rx_tick       = 0;
    int                   settings_used = 0;
    logic [PeerW-1:0]     cur_id        = '0;
    int                   peer_pool[$];
    logic                 left_requesting = 1'b0;

    ricart_agrawala_mutex_node_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    ricart_agrawala_mutex_node_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tlast       (m_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .pending       (pending),
        .result_count  (result_count),
        .lamport_now   (lamport_now),
        .req_stamp_now (req_stamp_now)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // receiver: random stall patterns plus an occasional long hold-off
    always @(posedge clk)
    begin
        rx_tick++;
        if (!rst_n)
            m_tready <= 1'b0;
        else if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else if (hold_seen != hold_asks)
        begin
            hold_seen = hold_asks;
            hold_left = HOLD_CYCLES;
            m_tready <= 1'b0;
        end
        else
        begin
            if (rx_left == 0)
            begin
                rx_mode = $urandom_range(0, 3);
                rx_left = $urandom_range(10, 60);
            end
            rx_left--;
            case (rx_mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= 1'($urandom_range(0, 1));
                2:       m_tready <= ($urandom_range(0, 3) == 0);
                default: m_tready <= (rx_tick % 3 != 0);
            endcase
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("%0t: timeout after %0d cycles", $time, cycle_count);
        $display("*** FAILED ***");
        $finish;
    end

    function automatic logic [ClockW-1:0] stamp_near(input logic [ClockW-1:0] base,
                                                     input int spread);
        int v;
        v = int'(base) + int'($urandom_range(0, 2 * spread)) - spread;
        if (v < 0)
            v = 0;
        if (v > 65535)
            v = 65535;
        return ClockW'(v);
    endfunction

    function automatic logic [PeerW-1:0] any_peer();
        if (peer_pool.size() == 0)
            return PeerW'($urandom_range(0, 15));
        return PeerW'(peer_pool[$urandom_range(0, peer_pool.size() - 1)]);
    endfunction

    task automatic send_item(input logic [OpW-1:0] op, input logic [PeerW-1:0] peer,
                             input logic [ClockW-1:0] stamp);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 5) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 6);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 50)
                                                     : $urandom_range(1, 10);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, stamp, peer, op};
        do
            @(posedge clk);
        while (!s_tready);
        burst_left--;
        sent_items++;
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CfgIndexW-1:0] idx, input logic [CfgDataW-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
    endtask

    task automatic configure(input logic [CfgDataW-1:0] id_val,
                             input logic [CfgDataW-1:0] count_val);
        int n;
        write_reg(CFG_NODE_ID, id_val);
        write_reg(CFG_NODE_COUNT, count_val);
        cfg_valid <= 1'b0;
        cur_id = id_val[PeerW-1:0];
        n = (int'(count_val) > PeerSlots) ? PeerSlots : int'(count_val);
        peer_pool.delete();
        for (int i = 0; i < n; i++)
            if (i != cur_id)
                peer_pool.push_back(i);
        settings_used++;
    endtask

    task automatic noise_item();
        logic [OpW-1:0]    op;
        logic [PeerW-1:0]  peer;
        logic [ClockW-1:0] stamp;
        op    = OpW'($urandom_range(0, 3));
        peer  = PeerW'($urandom_range(0, 15));
        stamp = ClockW'($urandom_range(0, 65535));
        // keep the clock near the run unless the message is dropped anyway
        if (op == OP_RECV_REQ || op == OP_RECV_REP)
            foreach (peer_pool[j])
                if (peer_pool[j] == peer)
                    stamp = stamp_near(lamport_now, 4);
        send_item(op, peer, stamp);
    endtask

    task automatic mutex_session();
        int order[$];
        int j;
        int k;
        int tmp;
        int cut;
        if (left_requesting)
            send_item(OP_LOCAL_REL, PeerW'($urandom_range(0, 15)),
                      ClockW'($urandom_range(0, 65535)));
        repeat ($urandom_range(0, 2))
            send_item(OP_RECV_REQ, any_peer(), stamp_near(lamport_now, 3));
        send_item(OP_LOCAL_REQ, PeerW'($urandom_range(0, 15)), ClockW'($urandom_range(0, 65535)));
        if ($urandom_range(0, 5) == 0)
            send_item(OP_LOCAL_REQ, PeerW'($urandom_range(0, 15)),
                      ClockW'($urandom_range(0, 65535)));
        order = peer_pool;
        for (j = order.size() - 1; j > 0; j--)
        begin
            k = $urandom_range(0, j);
            tmp = order[j];
            order[j] = order[k];
            order[k] = tmp;
        end
        cut = ($urandom_range(0, 7) == 0) ? $urandom_range(0, order.size()) : order.size();
        for (j = 0; j < cut; j++)
        begin
            if ($urandom_range(0, 2) == 0)
                send_item(OP_RECV_REQ, any_peer(), stamp_near(req_stamp_now, 2));
            if ($urandom_range(0, 11) == 0)
                noise_item();
            send_item(OP_RECV_REP, PeerW'(order[j]), stamp_near(lamport_now, 3));
            if ($urandom_range(0, 9) == 0)
                send_item(OP_RECV_REP, PeerW'(order[j]), stamp_near(lamport_now, 3));
        end
        repeat ($urandom_range(0, 3))
            send_item(OP_RECV_REQ, any_peer(), stamp_near(req_stamp_now, 2));
        if ($urandom_range(0, 4) == 0)
            left_requesting = 1'b1;
        else
        begin
            send_item(OP_LOCAL_REL, PeerW'($urandom_range(0, 15)),
                      ClockW'($urandom_range(0, 65535)));
            left_requesting = 1'b0;
        end
    endtask

    initial
    begin
        int                  rand_end;
        int                  phase;
        int                  waited;
        logic [CfgDataW-1:0] id_val;
        logic [CfgDataW-1:0] count_val;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: a single node
        send_item(OP_LOCAL_REQ, 4'd0, 16'h0000);   // no peers, enter at once
        send_item(OP_LOCAL_REQ, 4'd15, 16'hFFFF);  // already requesting
        send_item(OP_RECV_REQ, 4'd0, 16'd5);       // sender is this node
        send_item(OP_RECV_REP, 4'd5, 16'hFFFF);    // sender not a participant
        send_item(OP_LOCAL_REL, 4'd0, 16'd0);

        wait_idle();
        configure(5'd1, 5'd3);
        send_item(OP_RECV_REQ, 4'd0, 16'd10);      // idle node replies
        send_item(OP_RECV_REP, 4'd2, 16'd0);       // stray reply
        send_item(OP_LOCAL_REQ, 4'd0, 16'd0);
        send_item(OP_RECV_REQ, 4'd2, 16'd13);      // tie, own id lower: defer
        send_item(OP_RECV_REQ, 4'd0, 16'd13);      // tie, peer id lower: reply
        send_item(OP_RECV_REQ, 4'd0, 16'd20);      // later stamp: defer
        send_item(OP_RECV_REP, 4'd0, 16'd0);
        send_item(OP_RECV_REP, 4'd0, 16'd0);       // duplicate counts, enter
        send_item(OP_RECV_REP, 4'd2, 16'd0);       // nothing pending
        send_item(OP_LOCAL_REL, 4'd3, 16'd0);      // deferred replies
        send_item(OP_LOCAL_REQ, 4'd0, 16'd0);
        send_item(OP_RECV_REP, 4'd0, 16'd0);
        send_item(OP_LOCAL_REL, 4'd0, 16'd0);      // release while waiting
        send_item(OP_RECV_REP, 4'd2, 16'd0);

        wait_idle();
        write_reg(CFG_SPARE, 5'd31);
        configure(5'd21, 5'd3);                    // node id outside participants
        send_item(OP_LOCAL_REQ, 4'd0, 16'd0);
        send_item(OP_RECV_REP, 4'd2, 16'd0);
        send_item(OP_RECV_REP, 4'd0, 16'd0);
        send_item(OP_RECV_REP, 4'd1, 16'd0);
        send_item(OP_LOCAL_REL, 4'd0, 16'd0);

        rand_end = sent_items + RANDOM_ITEMS;
        phase = 0;
        while (sent_items < rand_end)
        begin
            case (phase)
                0:       begin id_val = 5'd0;  count_val = 5'd16; end
                1:       begin id_val = 5'd15; count_val = 5'd16; end
                2:       begin id_val = 5'd7;  count_val = 5'd3;  end
                3:       begin id_val = 5'd9;  count_val = 5'd0;  end
                4:       begin id_val = 5'd12; count_val = 5'd31; end
                5:       begin id_val = 5'd0;  count_val = 5'd2;  end
                6:       begin id_val = 5'd15; count_val = 5'd1;  end
                7:       begin id_val = 5'd3;  count_val = 5'd17; end
                default:
                begin
                    id_val    = CfgDataW'($urandom_range(0, 15));
                    count_val = ($urandom_range(0, 5) == 0) ? CfgDataW'($urandom_range(17, 31))
                                                            : CfgDataW'($urandom_range(1, 16));
                end
            endcase
            wait_idle();
            configure(id_val, count_val);
            if (phase == 1)
                hold_asks++;   // output held off while a full request scan is offered
            repeat ($urandom_range(1, 3))
            begin
                repeat ($urandom_range(0, 2))
                    noise_item();
                mutex_session();
            end
            phase++;
        end

        // drive the clock into saturation
        wait_idle();
        configure(5'd2, 5'd4);
        send_item(OP_RECV_REQ, 4'd0, 16'hFFFE);
        send_item(OP_RECV_REQ, 4'd1, 16'hFFFF);
        repeat (2) mutex_session();
        if (left_requesting)
            send_item(OP_LOCAL_REL, 4'd0, 16'd0);

        s_tvalid <= 1'b0;
        waited = 0;
        do
        begin
            @(posedge clk);
            waited++;
        end
        while (pending != 0 && waited < FINAL_WAIT);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pending != 0)
            $display("%0t: %0d expected items never arrived", $time, pending);

        $display("Run covered %0d input items and %0d output items over %0d node settings,",
                 sent_items, result_count, settings_used);
        $display("with deferrals, ties, stray replies, early releases and clock saturation.");
        if (fail_count == 0 && pending == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
